>>> rtl/pli_pkg.sv
// Package with sizes, codes and beat types of the positional list.
`timescale 1ns / 1ps
package pli_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  // Compare width that holds both a position and length + 1.
  localparam int CMP_W    = ((LEN_W > 7) ? LEN_W : 7) + 1;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } pli_status_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [6:0]         position;
    logic signed [31:0] value_in;
  } pli_in_t;

  typedef struct packed {
    pli_status_t        status;
    logic signed [31:0] value_out;
    logic [6:0]         list_count;
  } pli_out_t;

  // Broadcast from the control to every cell of the chain.
  typedef struct packed {
    logic               ins;
    logic               del;
    logic [IDX_W-1:0]   p_idx;
    logic signed [31:0] value;
  } pli_cell_ctrl_t;

endpackage

>>> rtl/pli_cell.sv
// One list entry: holds a word and shifts it toward either neighbor.
`timescale 1ns / 1ps
module pli_cell (
  input  logic                        clk,
  input  logic [pli_pkg::IDX_W-1:0]   cell_idx,
  input  pli_pkg::pli_cell_ctrl_t     ctrl,
  input  logic signed [31:0]          prev_data,
  input  logic signed [31:0]          next_data,
  output logic signed [31:0]          data_o,
  output logic signed [31:0]          rd_part
);

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    priority if (ctrl.ins) begin
      if (cell_idx > ctrl.p_idx) begin
        data_nxt = prev_data;
      end else if (cell_idx == ctrl.p_idx) begin
        data_nxt = ctrl.value;
      end
    end else if (ctrl.del) begin
      if (cell_idx >= ctrl.p_idx) begin
        data_nxt = next_data;
      end
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o  = data_r;
  // Only the addressed cell contributes to the read bus.
  assign rd_part = (cell_idx == ctrl.p_idx) ? data_r : '0;

endmodule

>>> rtl/positional_list_insert_delete_top.sv
// Top level: operation decode, cell chain and registered result beat.
// The registered result beat is valid in the cycle after its input is accepted.
// Throughput: one operation per cycle unless a held result is not taken.
// A new beat is accepted while the held result is taken in the same cycle.
// Reset empties the list and drops any held result; cell and result words stay undefined.
`timescale 1ns / 1ps
module positional_list_insert_delete_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pli_pkg::pli_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pli_pkg::pli_out_t out_data
);

  logic [pli_pkg::LEN_W-1:0] length_r;
  logic [pli_pkg::LEN_W-1:0] length_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  pli_pkg::pli_out_t         out_data_r;
  pli_pkg::pli_out_t         out_data_nxt;

  logic                      in_fire;
  logic                      do_ins;
  logic                      do_del;
  logic [pli_pkg::CMP_W-1:0] len_c;
  logic [pli_pkg::CMP_W-1:0] pos_c;
  logic [pli_pkg::CMP_W-1:0] len_nxt_c;
  logic signed [31:0]        rd_val;
  pli_pkg::pli_cell_ctrl_t   ctrl;

  logic signed [31:0] cell_data [pli_pkg::CAPACITY];
  logic signed [31:0] rd_part   [pli_pkg::CAPACITY];

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign len_c = pli_pkg::CMP_W'(length_r);
  assign pos_c = pli_pkg::CMP_W'(in_data.position);

  assign ctrl.ins   = do_ins && in_fire;
  assign ctrl.del   = do_del && in_fire;
  assign ctrl.p_idx = pli_pkg::IDX_W'(pos_c - pli_pkg::CMP_W'(1));
  assign ctrl.value = in_data.value_in;

  genvar g;
  generate
    for (g = 0; g < pli_pkg::CAPACITY; g++) begin : g_cell
      logic signed [31:0] prev_w;
      logic signed [31:0] next_w;
      if (g == 0) begin : g_first
        assign prev_w = '0;
      end else begin : g_mid_prev
        assign prev_w = cell_data[g-1];
      end
      if (g == pli_pkg::CAPACITY - 1) begin : g_last
        assign next_w = '0;
      end else begin : g_mid_next
        assign next_w = cell_data[g+1];
      end
      pli_cell u_cell (
        .clk       (clk),
        .cell_idx  (pli_pkg::IDX_W'(g)),
        .ctrl      (ctrl),
        .prev_data (prev_w),
        .next_data (next_w),
        .data_o    (cell_data[g]),
        .rd_part   (rd_part[g])
      );
    end
  endgenerate

  always_comb begin
    rd_val = '0;
    for (int i = 0; i < pli_pkg::CAPACITY; i++) begin
      rd_val = rd_val | rd_part[i];
    end
  end

  always_comb begin
    do_ins                 = 1'b0;
    do_del                 = 1'b0;
    length_nxt             = length_r;
    out_data_nxt.status    = pli_pkg::ST_RANGE;
    out_data_nxt.value_out = '0;
    unique case (in_data.operation)
      pli_pkg::OP_INSERT: begin
        if (pos_c != '0 && pos_c <= len_c + pli_pkg::CMP_W'(1)) begin
          if (length_r == pli_pkg::LEN_W'(pli_pkg::CAPACITY)) begin
            out_data_nxt.status = pli_pkg::ST_FULL;
          end else begin
            out_data_nxt.status = pli_pkg::ST_OK;
            do_ins              = 1'b1;
            length_nxt          = length_r + pli_pkg::LEN_W'(1);
          end
        end
      end
      pli_pkg::OP_DELETE, pli_pkg::OP_READ: begin
        if (pos_c != '0 && pos_c <= len_c) begin
          out_data_nxt.status    = pli_pkg::ST_OK;
          out_data_nxt.value_out = rd_val;
          if (in_data.operation == pli_pkg::OP_DELETE) begin
            do_del     = 1'b1;
            length_nxt = length_r - pli_pkg::LEN_W'(1);
          end
        end
      end
      default: begin
        out_data_nxt.status = pli_pkg::ST_RANGE;
      end
    endcase
    len_nxt_c               = pli_pkg::CMP_W'(length_nxt);
    out_data_nxt.list_count = len_nxt_c[6:0];
    out_valid_nxt           = in_fire || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        length_r <= length_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> dv/positional_list_checker.sv
// Result checker for the positional list: tracks the list and compares result beats.
`timescale 1ns / 1ps
module positional_list_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  pli_pkg::pli_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  pli_pkg::pli_out_t out_data,
  output int                fail_count,
  output int                pending,
  output int                results_seen,
  output int                full_seen,
  output int                range_seen
);

  logic signed [31:0] list_words [pli_pkg::CAPACITY];
  int                 list_len;
  pli_pkg::pli_out_t  awaited_results [$];
  pli_pkg::pli_out_t  want;

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    full_seen    = 0;
    range_seen   = 0;
    list_len     = 0;
  end

  // Applies one operation to the tracked list and returns the result it must produce.
  function automatic pli_pkg::pli_out_t apply_list_op(input pli_pkg::pli_in_t req);
    pli_pkg::pli_out_t r;
    int                p;
    int                k;
    r.status    = pli_pkg::ST_RANGE;
    r.value_out = '0;
    p           = int'(req.position);
    case (req.operation)
      pli_pkg::OP_INSERT: begin
        if (p >= 1 && p <= list_len + 1) begin
          if (list_len >= pli_pkg::CAPACITY) begin
            r.status = pli_pkg::ST_FULL;
          end else begin
            for (k = list_len; k >= p; k--) list_words[k] = list_words[k-1];
            list_words[p-1] = req.value_in;
            list_len++;
            r.status = pli_pkg::ST_OK;
          end
        end
      end
      pli_pkg::OP_DELETE, pli_pkg::OP_READ: begin
        if (p >= 1 && p <= list_len) begin
          r.value_out = list_words[p-1];
          if (req.operation == pli_pkg::OP_DELETE) begin
            for (k = p; k < list_len; k++) list_words[k-1] = list_words[k];
            list_len--;
          end
          r.status = pli_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    r.list_count = 7'(list_len);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      list_len = 0;
      awaited_results.delete();
    end else begin
      // The result leaving at this edge always belongs to an earlier input beat.
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result beat: status %0d value %0d count %0d", $time,
                     out_data.status, out_data.value_out, out_data.list_count);
        end else begin
          want = awaited_results.pop_front();
          if (want.status == pli_pkg::ST_FULL) full_seen++;
          if (want.status == pli_pkg::ST_RANGE) range_seen++;
          if (out_data.status !== want.status || out_data.value_out !== want.value_out ||
              out_data.list_count !== want.list_count) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch: status %0d/%0d value %0d/%0d count %0d/%0d (exp/got)",
                       $time, want.status, out_data.status, want.value_out,
                       out_data.value_out, want.list_count, out_data.list_count);
          end
        end
      end
      if (in_valid && in_ready) awaited_results.push_back(apply_list_op(in_data));
    end
    pending = awaited_results.size();
  end

endmodule

>>> dv/positional_list_insert_delete_top_tb.sv
// Testbench top for the positional list: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module positional_list_insert_delete_top_tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int LONG_HOLD = 300;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  pli_pkg::pli_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  pli_pkg::pli_out_t out_data;

  int fail_count, pending, results_seen, full_seen, range_seen;
  int send_idle = 11;
  int recv_idle = 66;
  int list_len_est = 0;
  int ops_sent = 0;
  bit hold_on = 0;
  bit hold_done = 0;
  int held = 0;
  bit filling = 1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  positional_list_insert_delete_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  positional_list_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .full_seen    (full_seen),
    .range_seen   (range_seen)
  );

  // Result side: random back-pressure, plus one long hold-off once requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_on && !hold_done) begin
        out_ready <= 1'b0;
        held++;
        if (held == LONG_HOLD) hold_done = 1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_op(input logic [1:0] op, input logic [6:0] pos,
                         input logic signed [31:0] val);
    pli_pkg::pli_in_t beat;
    beat.operation = op;
    beat.position  = pos;
    beat.value_in  = val;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ops_sent++;
    // Keep a rough list length so that random positions mostly land in range.
    if (op == pli_pkg::OP_INSERT && pos >= 1 && pos <= list_len_est + 1 &&
        list_len_est < pli_pkg::CAPACITY)
      list_len_est++;
    else if (op == pli_pkg::OP_DELETE && pos >= 1 && pos <= list_len_est)
      list_len_est--;
  endtask

  // Random beat, biased toward growing or shrinking the list depending on the mode.
  task automatic send_random();
    logic [1:0]         op;
    logic [6:0]         pos;
    logic signed [31:0] val;
    int                 roll;
    int                 top;
    roll = $urandom_range(99);
    if (roll < 3)        op = OP_UNUSED;
    else if (roll < 15)  op = pli_pkg::OP_READ;
    else if (roll < 79)  op = filling ? pli_pkg::OP_INSERT : pli_pkg::OP_DELETE;
    else                 op = filling ? pli_pkg::OP_DELETE : pli_pkg::OP_INSERT;
    top = (op == pli_pkg::OP_INSERT) ? list_len_est + 1 : list_len_est;
    if (top >= 1 && $urandom_range(99) < 85) pos = 7'($urandom_range(top, 1));
    else                                     pos = 7'($urandom_range(127, 0));
    case ($urandom_range(11))
      0:       val = WORD_MIN;
      1:       val = WORD_MAX;
      2:       val = -1;
      default: val = $urandom;
    endcase
    send_op(op, pos, val);
    if (list_len_est == pli_pkg::CAPACITY && $urandom_range(3) == 0) filling = 0;
    if (list_len_est == 0 && $urandom_range(3) == 0) filling = 1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list, bad positions and the unused code.
    send_op(pli_pkg::OP_READ,   7'd1,   32'sd5);
    send_op(pli_pkg::OP_DELETE, 7'd1,   32'sd0);
    send_op(pli_pkg::OP_INSERT, 7'd0,   32'sd7);
    send_op(pli_pkg::OP_INSERT, 7'd2,   32'sd7);
    send_op(OP_UNUSED,          7'd0,   32'sd1);
    // Front, end and middle inserts with extreme values.
    send_op(pli_pkg::OP_INSERT, 7'd1,   WORD_MIN);
    send_op(pli_pkg::OP_INSERT, 7'd1,   WORD_MAX);
    send_op(pli_pkg::OP_INSERT, 7'd3,   -32'sd1);
    send_op(pli_pkg::OP_INSERT, 7'd2,   32'sd0);
    send_op(pli_pkg::OP_INSERT, 7'd6,   32'sd9);
    send_op(pli_pkg::OP_INSERT, 7'd127, 32'sd9);
    send_op(OP_UNUSED,          7'd1,   32'sd3);
    send_op(pli_pkg::OP_READ,   7'd1,   32'sd0);
    send_op(pli_pkg::OP_READ,   7'd4,   32'sd0);
    send_op(pli_pkg::OP_READ,   7'd5,   32'sd0);
    send_op(pli_pkg::OP_READ,   7'd127, 32'sd0);
    send_op(pli_pkg::OP_DELETE, 7'd0,   32'sd0);
    send_op(pli_pkg::OP_DELETE, 7'd5,   32'sd0);
    send_op(pli_pkg::OP_DELETE, 7'd2,   32'sd0);
    send_op(pli_pkg::OP_DELETE, 7'd3,   32'sd0);
    send_op(pli_pkg::OP_DELETE, 7'd1,   32'sd0);
    send_op(pli_pkg::OP_READ,   7'd1,   32'sd0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 11; recv_idle = 66; end
        1: begin send_idle = 66; recv_idle = 11; end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          // The sender keeps offering beats through this hold so the input stalls.
          hold_on = 1;
        end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_random();
    end
    in_valid <= 1'b0;

    // Sample the checker's queue depth away from the clock edge where it changes.
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    $display("Sent %0d operations and compared %0d results.", ops_sent, results_seen);
    $display("Refusals seen: %0d for a full list, %0d for a bad position or code.",
             full_seen, range_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
